/* rtl/tile_sprite_pixel_compositor_core_macros.svh */
// Assertion macros for the compositor checker
`ifndef TILE_SPRITE_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define TILE_SPRITE_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define TSPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TSPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/tspc_pkg.sv */
// Package: constants and types of the tile/sprite compositor
`default_nettype none
package tspc_pkg;
  localparam int MemAddrBits = 16;
  localparam int SpriteCount = 127;
  localparam int SprBits     = 7;
  localparam logic [15:0] TileMapBase = 16'h0401;
  localparam logic [15:0] SpriteBase  = 16'h0602;
  localparam logic [15:0] ScrollXAddr = 16'h0800;
  localparam logic [15:0] ScrollYAddr = 16'h0801;
  localparam logic        OpWrite = 1'b0;
  localparam logic        OpQuery = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [15:0] address;
    logic [7:0] write_data;
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [1:0] red;
    logic [1:0] green;
    logic [1:0] blue;
    logic       sprite_hit;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/tspc_if.sv */
// Valid/ready channel interface carrying a payload
`default_nettype none
interface tspc_req_if;
  logic valid;
  logic ready;
  tspc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tspc_rsp_if;
  logic valid;
  logic ready;
  tspc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/tspc_ram.sv */
// Byte memory, one port, registered read data
`default_nettype none
module tspc_ram #(
  parameter int AddrBits = 16
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] addr_i,
  input  wire logic [7:0]          wdata_i,
  output logic      [7:0]          rdata_o
);
  logic [7:0] mem [2**AddrBits];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/tile_sprite_pixel_compositor_core.sv */
// Top level: memory-backed tile and sprite pixel compositor
// channel | dir | payload
// in_ch   | in  | operation, address, write_data, pixel_x, pixel_y
// out_ch  | out | red, green, blue, sprite_hit
// A write goes straight to memory when accepted. Every memory read goes through
// the single port, address issued in StRd and data taken in the state in ret_q:
// scroll X, scroll Y, the tile pointer and background pixel, then X and Y of each
// sprite, plus its pattern pointer and pixel byte if it lands on the pixel.
// Reset clears control only; memory holds garbage until written.
// A finished result waits in the output register; a stalled output stalls
// only the next query, writes still flow.
`default_nettype none
module tile_sprite_pixel_compositor_core (
  input wire logic clk_i,
  input wire logic rst_ni,
  tspc_req_if.sink   in_ch,
  tspc_rsp_if.source out_ch
);
  localparam int AB = tspc_pkg::MemAddrBits;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StRd    = 11'b00000000010, // issue read, next cycle data valid
    StSx    = 11'b00000000100,
    StSy    = 11'b00000001000,
    StTh    = 11'b00000010000,
    StTl    = 11'b00000100000,
    StBg    = 11'b00001000000,
    StSpX   = 11'b00010000000,
    StSpY   = 11'b00100000000,
    StSpH   = 11'b01000000000,
    StSpL   = 11'b10000000000
  } state_e;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;   // state consuming read data
  logic        pix_q, pix_d;   // read in flight for pixel byte (sprite)
  logic [6:0]  px_q, px_d, py_q, py_d, gx_q, gx_d, gy_q, gy_d;
  logic [7:0]  tmp_q, tmp_d, colour_q, colour_d;
  logic [2:0]  dx_q, dx_d;
  logic        hit_q, hit_d;
  logic [tspc_pkg::SprBits-1:0] k_q, k_d;
  logic [15:0] addr_q, addr_d;
  logic        ov_q, ov_d;
  tspc_pkg::rsp_t od_q, od_d;

  logic        we;
  logic [AB-1:0] ram_addr;
  logic [7:0]  rdata;
  logic [15:0] ent;
  logic [8:0]  dxs, dys;

  tspc_ram #(.AddrBits(AB)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ram_addr),
    .wdata_i(in_ch.data.write_data), .rdata_o(rdata)
  );

  assign in_ch.ready = (state_q == StIdle) &&
    (in_ch.data.operation == tspc_pkg::OpWrite || !ov_q);
  assign we = in_ch.valid && in_ch.ready && in_ch.data.operation == tspc_pkg::OpWrite;
  assign ram_addr = we ? in_ch.data.address[AB-1:0] : addr_q[AB-1:0];
  assign out_ch.valid = ov_q;
  assign out_ch.data = od_q;
  assign ent = tspc_pkg::SpriteBase + {7'd0, k_q, 2'd0};
  assign dxs = {2'b0, px_q} - {tmp_q[7], tmp_q};
  assign dys = {2'b0, py_q} - {rdata[7], rdata};

  always_comb begin
    state_d = state_q; ret_d = ret_q; pix_d = pix_q;
    px_d = px_q; py_d = py_q; gx_d = gx_q; gy_d = gy_q;
    tmp_d = tmp_q; colour_d = colour_q; dx_d = dx_q; hit_d = hit_q;
    k_d = k_q; addr_d = addr_q; ov_d = ov_q; od_d = od_q;
    if (out_ch.valid && out_ch.ready) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_ch.valid && in_ch.ready &&
            in_ch.data.operation == tspc_pkg::OpQuery) begin
          px_d = in_ch.data.pixel_x; py_d = in_ch.data.pixel_y;
          hit_d = 1'b0; k_d = '0; pix_d = 1'b0;
          addr_d = tspc_pkg::ScrollXAddr; ret_d = StSx; state_d = StRd;
        end
      end
      StRd: state_d = ret_q;
      StSx: begin
        gx_d = px_q - rdata[6:0];
        addr_d = tspc_pkg::ScrollYAddr; ret_d = StSy; state_d = StRd;
      end
      StSy: begin
        gy_d = py_q - rdata[6:0];
        addr_d = tspc_pkg::TileMapBase + {7'd0, gy_d[6:3], gx_q[6:3], 1'b0};
        ret_d = StTh; state_d = StRd;
      end
      StTh: begin
        tmp_d = rdata; addr_d = addr_q + 16'd1; ret_d = StTl; state_d = StRd;
      end
      StTl: begin
        addr_d = {tmp_q, rdata} + {10'd0, gx_q[2:0], gy_q[2:0]};
        ret_d = StBg; state_d = StRd;
      end
      StBg: begin
        if (pix_q) begin
          if (rdata[7]) begin colour_d = rdata; hit_d = 1'b1; end
        end else begin
          colour_d = rdata;
        end
        pix_d = 1'b0;
        if (pix_q && k_q == tspc_pkg::SprBits'(tspc_pkg::SpriteCount - 1)) begin
          od_d = '{red: colour_d[5:4], green: colour_d[3:2], blue: colour_d[1:0],
                   sprite_hit: hit_d};
          ov_d = 1'b1; state_d = StIdle;
        end else begin
          if (pix_q) k_d = k_q + 1'b1;
          addr_d = tspc_pkg::SpriteBase + {7'd0, k_d, 2'd0};
          ret_d = StSpX; state_d = StRd;
        end
      end
      StSpX: begin
        tmp_d = rdata; addr_d = ent + 16'd1; ret_d = StSpY; state_d = StRd;
      end
      StSpY: begin
        if (dxs[8:3] == '0 && dys[8:3] == '0) begin
          dx_d = dxs[2:0]; gy_d = {4'd0, dys[2:0]};
          addr_d = ent + 16'd2; ret_d = StSpH; state_d = StRd;
        end else if (k_q == tspc_pkg::SprBits'(tspc_pkg::SpriteCount - 1)) begin
          od_d = '{red: colour_q[5:4], green: colour_q[3:2], blue: colour_q[1:0],
                   sprite_hit: hit_q};
          ov_d = 1'b1; state_d = StIdle;
        end else begin
          k_d = k_q + 1'b1;
          addr_d = tspc_pkg::SpriteBase + {7'd0, k_d, 2'd0};
          ret_d = StSpX; state_d = StRd;
        end
      end
      StSpH: begin
        tmp_d = rdata; addr_d = addr_q + 16'd1; ret_d = StSpL; state_d = StRd;
      end
      StSpL: begin
        addr_d = {tmp_q, rdata} + {10'd0, dx_q, gy_q[2:0]};
        pix_d = 1'b1; ret_d = StBg; state_d = StRd;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ret_q <= StIdle; ov_q <= 1'b0; pix_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; ov_q <= ov_d; pix_q <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d; gx_q <= gx_d; gy_q <= gy_d;
    tmp_q <= tmp_d; colour_q <= colour_d; dx_q <= dx_d; hit_q <= hit_d;
    k_q <= k_d; addr_q <= addr_d; od_q <= od_d;
  end
endmodule
`default_nettype wire

/* rtl/tspc_checker.sv */
// Port-level checker for the compositor, bound to the top level
`default_nettype none
`include "tile_sprite_pixel_compositor_core_macros.svh"
module tspc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [6:0] out_data
);
  `TSPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `TSPC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid && in_ready && in_op, !in_ready)
  `TSPC_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_valid && in_ready && !in_op && !out_valid, !out_valid)
  `TSPC_ASSERT_IMPL(a_no_query_full, clk_i, rst_ni, out_valid && in_valid && in_op, !in_ready)
endmodule

bind tile_sprite_pixel_compositor_core tspc_checker u_tspc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.data.operation),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

/* test/tb.sv */
// Testbench for the tile and sprite pixel compositor: shadow memory predictor and checks
`default_nettype none
module tb;
  typedef struct {
    tspc_pkg::req_t req;
    bit   drain;
  } stim_t;

  logic clk;
  logic rst_n;

  tspc_req_if in_ch ();
  tspc_rsp_if out_ch ();

  tile_sprite_pixel_compositor_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  localparam logic [15:0] MemMask = 16'((32'd1 << tspc_pkg::MemAddrBits) - 1);
  localparam logic [15:0] PoolBase = 16'h2000;
  localparam logic [15:0] WrapPool = 16'hFFE0;

  logic [7:0] shadow_mem [65536];
  stim_t      pending [$];
  tspc_pkg::rsp_t pixel_expect [$];
  int         fail_cnt = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         draining = 0;
  bit         calm = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] mem_rd(logic [31:0] a);
    return shadow_mem[a[15:0] & MemMask];
  endfunction

  function automatic tspc_pkg::rsp_t predict_pixel(tspc_pkg::req_t q);
    logic [6:0]  gx, gy;
    logic [7:0]  tile_idx, colour, c;
    logic [15:0] base, ent, sb;
    int          dx, dy;
    bit          hit;
    tspc_pkg::rsp_t r;
    hit = 0;
    gx = 7'(q.pixel_x - mem_rd(tspc_pkg::ScrollXAddr));
    gy = 7'(q.pixel_y - mem_rd(tspc_pkg::ScrollYAddr));
    tile_idx = {gy[6:3], gx[6:3]};
    base = {mem_rd(tspc_pkg::TileMapBase + 2 * tile_idx),
            mem_rd(tspc_pkg::TileMapBase + 2 * tile_idx + 1)};
    colour = mem_rd(base + gx[2:0] * 8 + gy[2:0]);
    for (int k = 0; k < tspc_pkg::SpriteCount; k++) begin
      ent = tspc_pkg::SpriteBase + 16'(4 * k);
      dx = int'(q.pixel_x) - int'($signed(mem_rd(ent)));
      dy = int'(q.pixel_y) - int'($signed(mem_rd(ent + 1)));
      if (dx >= 0 && dx < 8 && dy >= 0 && dy < 8) begin
        sb = {mem_rd(ent + 2), mem_rd(ent + 3)};
        c = mem_rd(sb + dx * 8 + dy);
        if (c[7]) begin
          colour = c;
          hit = 1;
        end
      end
    end
    r.red = colour[5:4];
    r.green = colour[3:2];
    r.blue = colour[1:0];
    r.sprite_hit = hit;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // pattern pointers always land in a fully written pool, including one that wraps at 64K
  function automatic logic [15:0] pick_pattern();
    if ($urandom_range(0, 7) == 0) return WrapPool;
    return PoolBase + 16'($urandom_range(0, 192));
  endfunction

  function automatic bit is_ptr_byte(logic [15:0] a);
    if (a >= tspc_pkg::TileMapBase && a <= tspc_pkg::TileMapBase + 16'h01FF) return 1;
    if (a >= tspc_pkg::SpriteBase &&
        a <= tspc_pkg::SpriteBase + 16'(4 * tspc_pkg::SpriteCount - 1))
      return ((a - tspc_pkg::SpriteBase) % 4) >= 2;
    return 0;
  endfunction

  task automatic push_write(logic [15:0] a, logic [7:0] d);
    stim_t s;
    s.drain = 0;
    s.req.operation = tspc_pkg::OpWrite;
    s.req.address = a;
    s.req.write_data = d;
    s.req.pixel_x = 7'($urandom);
    s.req.pixel_y = 7'($urandom);
    pending.push_back(s);
  endtask

  task automatic push_query(logic [6:0] x, logic [6:0] y);
    stim_t s;
    s.drain = 0;
    s.req.operation = tspc_pkg::OpQuery;
    s.req.address = 16'($urandom);
    s.req.write_data = 8'($urandom);
    s.req.pixel_x = x;
    s.req.pixel_y = y;
    pending.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s.drain = 1;
    s.req = '0;
    pending.push_back(s);
  endtask

  task automatic set_ptr(logic [15:0] a, logic [15:0] p);
    push_write(a, p[15:8]);
    push_write(a + 16'd1, p[7:0]);
  endtask

  task automatic set_sprite(int k, logic [7:0] x, logic [7:0] y, logic [15:0] p);
    push_write(tspc_pkg::SpriteBase + 16'(4 * k), x);
    push_write(tspc_pkg::SpriteBase + 16'(4 * k) + 16'd1, y);
    set_ptr(tspc_pkg::SpriteBase + 16'(4 * k) + 16'd2, p);
  endtask

  // driver: predicts each accepted transaction, then presents the next one
  always @(posedge clk) begin
    stim_t it;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.operation == tspc_pkg::OpQuery)
          pixel_expect.push_back(predict_pixel(in_ch.data));
        else shadow_mem[in_ch.data.address & MemMask] = in_ch.data.write_data;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (draining) begin
          if (pixel_expect.size() == 0) draining = 0;
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          it = pending.pop_front();
          if (it.drain) begin
            draining = 1;
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid <= 1'b1;
            in_ch.data <= it.req;
            gap_left = idle_len();
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transaction with the oldest prediction
  always @(posedge clk) begin
    tspc_pkg::rsp_t exp_px;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_expect.size() == 0) begin
          $error("result with no pending query");
          fail_cnt++;
        end else begin
          exp_px = pixel_expect.pop_front();
          if (out_ch.data.red !== exp_px.red) begin
            $error("red expected %0d got %0d", exp_px.red, out_ch.data.red);
            fail_cnt++;
          end
          if (out_ch.data.green !== exp_px.green) begin
            $error("green expected %0d got %0d", exp_px.green, out_ch.data.green);
            fail_cnt++;
          end
          if (out_ch.data.blue !== exp_px.blue) begin
            $error("blue expected %0d got %0d", exp_px.blue, out_ch.data.blue);
            fail_cnt++;
          end
          if (out_ch.data.sprite_hit !== exp_px.sprite_hit) begin
            $error("sprite_hit expected %0d got %0d", exp_px.sprite_hit,
                   out_ch.data.sprite_hit);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    int r;
    logic [15:0] a;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 65536; i++) shadow_mem[i] = 8'h00;

    // load every byte a query can read: pools, tile map, sprite table, scroll
    for (int i = 0; i < 256; i++) push_write(PoolBase + 16'(i), 8'($urandom));
    for (int i = 0; i < 64; i++) push_write(WrapPool + 16'(i), 8'($urandom));
    for (int t = 0; t < 256; t++) set_ptr(tspc_pkg::TileMapBase + 16'(2 * t), pick_pattern());
    for (int k = 0; k < tspc_pkg::SpriteCount; k++)
      set_sprite(k, 8'($urandom), 8'($urandom), pick_pattern());
    push_write(tspc_pkg::ScrollXAddr, 8'h00);
    push_write(tspc_pkg::ScrollYAddr, 8'h00);

    // directed: corners, scroll extremes, clipped sprites, priority, wrapping pattern
    push_query(7'd0, 7'd0);
    push_query(7'd127, 7'd127);
    set_ptr(tspc_pkg::TileMapBase, WrapPool);
    push_query(7'd0, 7'd0);
    push_write(tspc_pkg::ScrollXAddr, 8'h7F);
    push_write(tspc_pkg::ScrollYAddr, 8'h80);
    push_query(7'd127, 7'd0);
    push_write(tspc_pkg::ScrollXAddr, 8'hFF);
    push_write(tspc_pkg::ScrollYAddr, 8'hFF);
    push_query(7'd0, 7'd127);
    push_write(PoolBase + 16'd3, 8'hFF);
    push_write(PoolBase + 16'd64, 8'hC5);
    set_sprite(0, 8'hFD, 8'hFE, PoolBase);
    push_query(7'd0, 7'd0);
    set_sprite(tspc_pkg::SpriteCount - 1, 8'h00, 8'h00, PoolBase + 16'd64);
    push_query(7'd0, 7'd0);
    set_sprite(1, 8'd124, 8'd124, PoolBase);
    push_query(7'd127, 7'd127);
    push_write(tspc_pkg::ScrollXAddr, 8'h00);
    push_write(tspc_pkg::ScrollYAddr, 8'h00);
    push_drain();

    for (int i = 0; i < 1150; i++) begin
      if (i == 400 || i == 800) push_drain();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_query(7'($urandom), 7'($urandom));
      end else if (r < 55) begin
        if ($urandom_range(0, 3) == 0)
          push_write(WrapPool + 16'($urandom_range(0, 63)), 8'($urandom));
        else push_write(PoolBase + 16'($urandom_range(0, 255)), 8'($urandom));
      end else if (r < 70) begin
        a = tspc_pkg::SpriteBase +
            16'(4 * $urandom_range(0, tspc_pkg::SpriteCount - 1) + $urandom_range(0, 1));
        push_write(a, $urandom_range(0, 1) ? 8'($urandom_range(0, 124)) : 8'($urandom));
      end else if (r < 75) begin
        push_write($urandom_range(0, 1) ? tspc_pkg::ScrollXAddr : tspc_pkg::ScrollYAddr,
                   8'($urandom));
      end else if (r < 85) begin
        if ($urandom_range(0, 1))
          set_ptr(tspc_pkg::TileMapBase + 16'(2 * $urandom_range(0, 255)), pick_pattern());
        else
          set_ptr(tspc_pkg::SpriteBase +
                  16'(4 * $urandom_range(0, tspc_pkg::SpriteCount - 1)) + 16'd2,
                  pick_pattern());
      end else begin
        a = 16'($urandom);
        // pointer bytes move elsewhere so no query follows a stray pointer
        if (is_ptr_byte(a) || (a >= PoolBase && a <= PoolBase + 16'h00FF)
            || a >= WrapPool || a < 16'h0020)
          a = a ^ 16'h4000;
        push_write(a, 8'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm = 1;
    repeat (3000) @(posedge clk);
    calm = 0;
    while (pending.size() > 0 || draining || in_ch.valid) @(posedge clk);
    while (pixel_expect.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (pixel_expect.size() != 0) begin
      $error("%0d queries left without a result", pixel_expect.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/tspc_pkg.sv
rtl/tspc_if.sv
rtl/tspc_ram.sv
rtl/tile_sprite_pixel_compositor_core.sv
rtl/tspc_checker.sv
test/tb.sv
